FILE: src/alfl_pkg.sv
package alfl_pkg;

	// Field widths of one request and one result
	localparam int ID_W    = 31;
	localparam int SEX_W   = 8;
	localparam int NAME_W  = 64;
	localparam int PROG_W  = 64;
	localparam int STAT_W  = 2;
	localparam int SLOT_W  = 4;

	// Stream widths, fields packed from bit 0 and padded to whole bytes
	localparam int S_FIELDS_W = ID_W + SEX_W + NAME_W + PROG_W;
	localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int S_PAD_W    = S_DATA_W - S_FIELDS_W;
	localparam int M_FIELDS_W = SLOT_W + ID_W + SEX_W + NAME_W + PROG_W;
	localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_DATA_W - M_FIELDS_W;

	// Request kinds
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOMATCH  = 2'd3;

	// Cursor source select
	localparam logic [1:0] CUR_HOLD = 2'd0;
	localparam logic [1:0] CUR_FREE = 2'd1;
	localparam logic [1:0] CUR_LIST = 2'd2;
	localparam logic [1:0] CUR_NEXT = 2'd3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic              load;
		logic [1:0]        cur_sel;
		logic              step;
		logic              insert;
		logic              unlink;
		logic              free;
		logic              res_load;
		logic [STAT_W-1:0] res_status;
	} ctrl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic fh_none;
		logic lh_none;
		logic match;
		logic next_none;
		logic out_busy;
	} ctrl_stat_t;

endpackage

FILE: src/alfl_ram.sv
module alfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, read one entry registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/alfl_ctrl.sv
module alfl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic                  s_mode,
	input  alfl_pkg::ctrl_stat_t  stat,
	output alfl_pkg::ctrl_cmd_t   cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_FREE = 3'd3;
	localparam logic [2:0] S_RESP = 3'd4;

	logic [2:0]                  state_q, state_d;
	logic [alfl_pkg::STAT_W-1:0] res_q, res_d;

	assign s_tready = (state_q == S_IDLE);

	// Sequence one request
	always_comb begin
		state_d        = state_q;
		res_d          = res_q;
		cmd            = '0;
		cmd.cur_sel    = alfl_pkg::CUR_HOLD;
		cmd.res_status = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (s_mode == alfl_pkg::MODE_INSERT) begin
						cmd.cur_sel = alfl_pkg::CUR_FREE;
						if (stat.fh_none) begin
							res_d   = alfl_pkg::ST_FULL;
							state_d = S_RESP;
						end else begin
							state_d = S_INS;
						end
					end else begin
						cmd.cur_sel = alfl_pkg::CUR_LIST;
						if (stat.lh_none) begin
							res_d   = alfl_pkg::ST_NOMATCH;
							state_d = S_RESP;
						end else begin
							state_d = S_WALK;
						end
					end
				end
			end
			S_INS: begin
				cmd.insert = 1'b1;
				res_d      = alfl_pkg::ST_INSERTED;
				state_d    = S_RESP;
			end
			S_WALK: begin
				if (stat.match) begin
					cmd.unlink = 1'b1;
					state_d    = S_FREE;
				end else if (stat.next_none) begin
					res_d   = alfl_pkg::ST_NOMATCH;
					state_d = S_RESP;
				end else begin
					cmd.cur_sel = alfl_pkg::CUR_NEXT;
					cmd.step    = 1'b1;
				end
			end
			S_FREE: begin
				cmd.free = 1'b1;
				res_d    = alfl_pkg::ST_REMOVED;
				state_d  = S_RESP;
			end
			S_RESP: begin
				if (!stat.out_busy) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= alfl_pkg::ST_INSERTED;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

endmodule

FILE: src/alfl_dp.sv
module alfl_dp #(
	parameter int SLOTS = 16,
	parameter int KW    = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  alfl_pkg::ctrl_cmd_t           cmd,
	output alfl_pkg::ctrl_stat_t          stat,
	input  logic [alfl_pkg::ID_W-1:0]     in_id,
	input  logic [alfl_pkg::SEX_W-1:0]    in_sex,
	input  logic [alfl_pkg::NAME_W-1:0]   in_name,
	input  logic [alfl_pkg::PROG_W-1:0]   in_prog,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [alfl_pkg::STAT_W-1:0]   out_status,
	output logic [alfl_pkg::SLOT_W-1:0]   out_slot,
	output logic [alfl_pkg::ID_W-1:0]     out_id,
	output logic [alfl_pkg::SEX_W-1:0]    out_sex,
	output logic [alfl_pkg::NAME_W-1:0]   out_name,
	output logic [alfl_pkg::PROG_W-1:0]   out_prog
);

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int LINK_W = $clog2(SLOTS + 1);
	localparam int SW     = (IDX_W > alfl_pkg::SLOT_W) ? IDX_W : alfl_pkg::SLOT_W;
	localparam int REC_W  = alfl_pkg::ID_W + alfl_pkg::SEX_W + KW + alfl_pkg::PROG_W;
	localparam logic [LINK_W-1:0] NONE = LINK_W'(SLOTS);

	// Request fields
	logic [alfl_pkg::ID_W-1:0]   in_id_q;
	logic [alfl_pkg::SEX_W-1:0]  in_sex_q;
	logic [KW-1:0]               in_key_q;
	logic [alfl_pkg::PROG_W-1:0] in_prog_q;

	// List pointers and walk cursor
	logic [LINK_W-1:0] free_head_q, list_head_q, low_q, cur_q, cur_d, prev_q;
	logic [IDX_W-1:0]  cur_idx, cur_dec;
	logic [LINK_W-1:0] link_rd, link_eff;
	logic              prev_none;

	// Memory ports
	logic              link_we;
	logic [IDX_W-1:0]  link_waddr;
	logic [LINK_W-1:0] link_wdata;
	logic [REC_W-1:0]  rec_wdata, rec_rd;

	// Captured record of a removal
	logic [alfl_pkg::ID_W-1:0]   rem_id_q;
	logic [alfl_pkg::SEX_W-1:0]  rem_sex_q;
	logic [KW-1:0]               rem_key_q;
	logic [alfl_pkg::PROG_W-1:0] rem_prog_q;

	// Result register
	logic                          out_valid_q;
	logic [alfl_pkg::STAT_W-1:0]   out_status_q;
	logic [alfl_pkg::SLOT_W-1:0]   out_slot_q;
	logic [alfl_pkg::ID_W-1:0]     out_id_q;
	logic [alfl_pkg::SEX_W-1:0]    out_sex_q;
	logic [alfl_pkg::NAME_W-1:0]   out_name_q;
	logic [alfl_pkg::PROG_W-1:0]   out_prog_q;
	logic [SW-1:0]                 cur_wide;
	logic                          slot_used, rec_used;

	assign cur_idx   = cur_q[IDX_W-1:0];
	assign cur_dec   = cur_idx - IDX_W'(1);
	assign prev_none = (prev_q == NONE);

	// Slots below the fill mark were never written; their reset link is made here from the slot number
	always_comb begin
		if (LINK_W'(cur_idx) < low_q) begin
			link_eff = (cur_idx == '0) ? NONE : LINK_W'(cur_dec);
		end else begin
			link_eff = link_rd;
		end
	end

	// Select the next cursor, which is also the read address
	always_comb begin
		case (cmd.cur_sel)
			alfl_pkg::CUR_FREE: cur_d = free_head_q;
			alfl_pkg::CUR_LIST: cur_d = list_head_q;
			alfl_pkg::CUR_NEXT: cur_d = link_eff;
			default:            cur_d = cur_q;
		endcase
	end

	// Link write port: new node, bypass of the removed node, or free push
	always_comb begin
		link_we    = cmd.insert | cmd.free | (cmd.unlink & ~prev_none);
		link_waddr = cur_idx;
		link_wdata = list_head_q;
		if (cmd.unlink) begin
			link_waddr = prev_q[IDX_W-1:0];
			link_wdata = link_eff;
		end else if (cmd.free) begin
			link_wdata = free_head_q;
		end
	end

	assign rec_wdata = {in_prog_q, in_key_q, in_sex_q, in_id_q};

	alfl_ram #(
		.WIDTH(LINK_W),
		.DEPTH(SLOTS)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (cur_d[IDX_W-1:0]),
		.rdata (link_rd)
	);

	alfl_ram #(
		.WIDTH(REC_W),
		.DEPTH(SLOTS)
	) u_rec_ram (
		.clk   (clk),
		.we    (cmd.insert),
		.waddr (cur_idx),
		.wdata (rec_wdata),
		.raddr (cur_d[IDX_W-1:0]),
		.rdata (rec_rd)
	);

	// Report status to the controller
	always_comb begin
		stat.fh_none   = (free_head_q == NONE);
		stat.lh_none   = (list_head_q == NONE);
		stat.match     = (rec_rd[alfl_pkg::ID_W+alfl_pkg::SEX_W +: KW] == in_key_q);
		stat.next_none = (link_eff == NONE);
		stat.out_busy  = out_valid_q & ~out_ready;
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_id_q   <= in_id;
			in_sex_q  <= in_sex;
			in_key_q  <= in_name[KW-1:0];
			in_prog_q <= in_prog;
		end
	end

	// Update pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= LINK_W'(SLOTS - 1);
			list_head_q <= NONE;
			low_q       <= NONE;
			cur_q       <= NONE;
			prev_q      <= NONE;
		end else begin
			cur_q <= cur_d;
			if (cmd.load) begin
				prev_q <= NONE;
			end else if (cmd.step) begin
				prev_q <= cur_q;
			end
			if (cmd.insert) begin
				free_head_q <= link_eff;
				list_head_q <= cur_q;
				if (cur_q < low_q) begin
					low_q <= cur_q;
				end
			end
			if (cmd.unlink && prev_none) begin
				list_head_q <= link_eff;
			end
			if (cmd.free) begin
				free_head_q <= cur_q;
			end
		end
	end

	// Hold the matched record
	always_ff @(posedge clk) begin
		if (cmd.unlink) begin
			rem_id_q   <= rec_rd[0 +: alfl_pkg::ID_W];
			rem_sex_q  <= rec_rd[alfl_pkg::ID_W +: alfl_pkg::SEX_W];
			rem_key_q  <= rec_rd[alfl_pkg::ID_W+alfl_pkg::SEX_W +: KW];
			rem_prog_q <= rec_rd[alfl_pkg::ID_W+alfl_pkg::SEX_W+KW +: alfl_pkg::PROG_W];
		end
	end

	assign cur_wide  = SW'(cur_idx);
	assign rec_used  = (cmd.res_status == alfl_pkg::ST_REMOVED);
	assign slot_used = rec_used || (cmd.res_status == alfl_pkg::ST_INSERTED);

	// Output register: load a result, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_status_q <= cmd.res_status;
			out_slot_q   <= slot_used ? cur_wide[alfl_pkg::SLOT_W-1:0] : '0;
			out_id_q     <= rec_used ? rem_id_q : '0;
			out_sex_q    <= rec_used ? rem_sex_q : '0;
			out_name_q   <= rec_used ? alfl_pkg::NAME_W'(rem_key_q) : '0;
			out_prog_q   <= rec_used ? rem_prog_q : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_slot   = out_slot_q;
	assign out_id     = out_id_q;
	assign out_sex    = out_sex_q;
	assign out_name   = out_name_q;
	assign out_prog   = out_prog_q;

	a_insert_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> (cur_q < NONE))
		else $error("insert into a slot outside the pool");

	a_unlink_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.unlink || cmd.free) |-> (cur_q < NONE))
		else $error("removal cursor outside the pool");

	a_res_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !(out_valid_q && !out_ready))
		else $error("result loaded over one still waiting");

	a_free_push: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.free |=> (free_head_q == $past(cur_q)))
		else $error("freed slot not at free head");

	a_insert_front: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> (list_head_q == $past(cur_q)))
		else $error("inserted slot not at list head");

endmodule

FILE: src/array_linked_list_with_free_list.sv
// Linked list of records in a fixed slot pool, with a free list in the same link memory.
// Requests enter on the s_ channel: s_tuser is the kind (0 insert at front, 1 remove
// the first record whose name matches); s_tdata carries the record or the key.
// Each request gives exactly one result on the m_ channel: m_tuser is the status
// (0 inserted, 1 pool full, 2 removed, 3 no match), m_tdata the slot and the
// removed record, all zero where nothing applies.
// From request accept to result: an insert passes the insert state, then the result
// state; a full pool or a remove from an empty list goes straight to the result state;
// a remove walks the list from the head and either unlinks and frees the match or
// ends at the tail, then goes to the result state. The walk follows one link per cycle
// through the read port of the link and record memories. One request is in work at a
// time; s_tready is high when the block is idle, which it is again once the result is
// loaded.
// A finished result waits in the output register while m_tready is low; the next
// request is then still accepted and worked up to its result, which waits for the
// register to empty.
// Reset (arst_n low) empties the list and puts all slots on the free list, top slot
// first; no clearing pass is needed, so requests are taken right after reset.
module array_linked_list_with_free_list #(
	parameter int SLOTS     = 16,
	parameter int KEY_BYTES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// student_id, sex_code, name_key, program_text, zero pad
	input  logic [alfl_pkg::S_DATA_W-1:0]   s_tdata,
	// mode
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// slot, removed_id, removed_sex, removed_name, removed_program, zero pad
	output logic [alfl_pkg::M_DATA_W-1:0]   m_tdata,
	// status
	output logic [alfl_pkg::STAT_W-1:0]     m_tuser
);

	localparam int KW = KEY_BYTES * 8;

	localparam int OFS_SEX  = alfl_pkg::ID_W;
	localparam int OFS_NAME = OFS_SEX + alfl_pkg::SEX_W;
	localparam int OFS_PROG = OFS_NAME + alfl_pkg::NAME_W;

	alfl_pkg::ctrl_cmd_t  cmd;
	alfl_pkg::ctrl_stat_t stat;

	logic [alfl_pkg::SLOT_W-1:0] out_slot;
	logic [alfl_pkg::ID_W-1:0]   out_id;
	logic [alfl_pkg::SEX_W-1:0]  out_sex;
	logic [alfl_pkg::NAME_W-1:0] out_name;
	logic [alfl_pkg::PROG_W-1:0] out_prog;

	alfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_mode   (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	alfl_dp #(
		.SLOTS (SLOTS),
		.KW    (KW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_id      (s_tdata[0 +: alfl_pkg::ID_W]),
		.in_sex     (s_tdata[OFS_SEX +: alfl_pkg::SEX_W]),
		.in_name    (s_tdata[OFS_NAME +: alfl_pkg::NAME_W]),
		.in_prog    (s_tdata[OFS_PROG +: alfl_pkg::PROG_W]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_slot   (out_slot),
		.out_id     (out_id),
		.out_sex    (out_sex),
		.out_name   (out_name),
		.out_prog   (out_prog)
	);

	// Pack the result fields from bit 0 up
	assign m_tdata = {{alfl_pkg::M_PAD_W{1'b0}}, out_prog, out_name, out_sex, out_id, out_slot};

endmodule

FILE: tb/sv/tb_array_linked_list_with_free_list.sv
module tb_array_linked_list_with_free_list;

	localparam int SLOTS       = 16;
	localparam int KEY_BYTES   = 8;
	localparam int LINK_W      = 5;
	localparam int RANDOM_REQS = 1625;
	localparam int PHASE_LEN   = 48;
	localparam int LONG_HOLD   = 400;
	localparam int IDLE_LIMIT  = 3000;
	localparam int DRAIN_WAIT  = 25;

	localparam logic [LINK_W-1:0] NO_LINK  = LINK_W'(SLOTS);
	localparam logic [alfl_pkg::NAME_W-1:0] KEY_MASK =
		{alfl_pkg::NAME_W{1'b1}} >> (8 * (8 - KEY_BYTES));

	typedef struct packed {
		logic                        mode;
		logic [alfl_pkg::ID_W-1:0]   id;
		logic [alfl_pkg::SEX_W-1:0]  sex;
		logic [alfl_pkg::NAME_W-1:0] name;
		logic [alfl_pkg::PROG_W-1:0] prog;
	} request_t;

	typedef struct packed {
		logic [alfl_pkg::STAT_W-1:0] status;
		logic [alfl_pkg::SLOT_W-1:0] slot;
		logic [alfl_pkg::ID_W-1:0]   id;
		logic [alfl_pkg::SEX_W-1:0]  sex;
		logic [alfl_pkg::NAME_W-1:0] name;
		logic [alfl_pkg::PROG_W-1:0] prog;
	} result_t;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [alfl_pkg::S_DATA_W-1:0] s_tdata  = '0;
	logic                          s_tuser  = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [alfl_pkg::M_DATA_W-1:0] m_tdata;
	logic [alfl_pkg::STAT_W-1:0]   m_tuser;

	// Shadow copy of the slot pool
	logic [alfl_pkg::ID_W-1:0]   pool_id   [SLOTS];
	logic [alfl_pkg::SEX_W-1:0]  pool_sex  [SLOTS];
	logic [alfl_pkg::NAME_W-1:0] pool_name [SLOTS];
	logic [alfl_pkg::PROG_W-1:0] pool_prog [SLOTS];
	logic [LINK_W-1:0]           pool_link [SLOTS];
	logic [LINK_W-1:0]           free_top;
	logic [LINK_W-1:0]           list_top;

	request_t pending_reqs [$];
	result_t  open_results [$];
	request_t offer_req;
	logic     offer_next;
	int       gap_left;
	int       hold_left;
	int       sent_cnt;
	int       results_seen;
	int       idle_cycles;
	int       fail_cnt;
	bit       long_hold_done;

	array_linked_list_with_free_list #(
		.SLOTS(SLOTS),
		.KEY_BYTES(KEY_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #6 clk = ~clk;

	// Empty list, every slot on the free list with the top slot first
	function automatic void reset_pool();
		for (int i = 0; i < SLOTS; i++) begin
			pool_id[i]   = '0;
			pool_sex[i]  = '0;
			pool_name[i] = '0;
			pool_prog[i] = '0;
			pool_link[i] = (i == 0) ? NO_LINK : LINK_W'(i - 1);
		end
		free_top = LINK_W'(SLOTS - 1);
		list_top = NO_LINK;
	endfunction

	// Apply one request to the shadow pool and return the result it gives
	function automatic result_t apply_to_pool(request_t req);
		result_t                     res;
		logic [alfl_pkg::NAME_W-1:0] key;
		logic [LINK_W-1:0]           prev;
		logic [LINK_W-1:0]           cur;
		logic [LINK_W-1:0]           s;
		bit                          found;
		res   = '0;
		key   = req.name & KEY_MASK;
		found = 1'b0;
		if (req.mode == alfl_pkg::MODE_INSERT) begin
			s = free_top;
			if (s >= NO_LINK) begin
				res.status = alfl_pkg::ST_FULL;
			end else begin
				free_top     = pool_link[s];
				pool_id[s]   = req.id;
				pool_sex[s]  = req.sex;
				pool_name[s] = key;
				pool_prog[s] = req.prog;
				pool_link[s] = list_top;
				list_top     = s;
				res.status   = alfl_pkg::ST_INSERTED;
				res.slot     = s[alfl_pkg::SLOT_W-1:0];
			end
		end else begin
			prev = NO_LINK;
			cur  = list_top;
			for (int n = 0; n < SLOTS && cur < NO_LINK && !found; n++) begin
				if (pool_name[cur] == key) begin
					found = 1'b1;
				end else begin
					prev = cur;
					cur  = pool_link[cur];
				end
			end
			if (found) begin
				res.status = alfl_pkg::ST_REMOVED;
				res.slot   = cur[alfl_pkg::SLOT_W-1:0];
				res.id     = pool_id[cur];
				res.sex    = pool_sex[cur];
				res.name   = pool_name[cur];
				res.prog   = pool_prog[cur];
				// unlink, then push the slot onto the free list cleared
				if (prev >= NO_LINK)
					list_top = pool_link[cur];
				else
					pool_link[prev] = pool_link[cur];
				pool_link[cur] = free_top;
				pool_id[cur]   = '0;
				pool_sex[cur]  = '0;
				pool_name[cur] = '0;
				pool_prog[cur] = '0;
				free_top       = cur;
			end else begin
				res.status = alfl_pkg::ST_NOMATCH;
			end
		end
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Mostly short gaps, a few long ones, none in a quiet stretch
	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void queue_req(logic mode, logic [31:0] id, logic [31:0] sex,
			logic [alfl_pkg::NAME_W-1:0] name, logic [alfl_pkg::PROG_W-1:0] prog);
		request_t req;
		req.mode = mode;
		req.id   = id[alfl_pkg::ID_W-1:0];
		req.sex  = sex[alfl_pkg::SEX_W-1:0];
		req.name = name;
		req.prog = prog;
		pending_reqs.push_back(req);
	endfunction

	// Offer requests from the pending queue, predict each one on accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
			gap_left = 0;
		end else begin
			offer_next = s_tvalid;
			if (s_tvalid && s_tready) begin
				open_results.push_back(apply_to_pool(offer_req));
				sent_cnt++;
				offer_next = 1'b0;
				gap_left = pick_gap((sent_cnt / 80) % 4 == 3);
			end
			if (!offer_next) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() > 0) begin
					offer_req  = pending_reqs.pop_front();
					offer_next = 1'b1;
				end
			end
			s_tvalid <= offer_next;
			s_tdata  <= {{alfl_pkg::S_PAD_W{1'b0}}, offer_req.prog, offer_req.name,
				offer_req.sex, offer_req.id};
			s_tuser  <= offer_req.mode;
		end
	end

	// Check each result against the oldest prediction, stall the output at random
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.slot   = m_tdata[0 +: alfl_pkg::SLOT_W];
				got.id     = m_tdata[alfl_pkg::SLOT_W +: alfl_pkg::ID_W];
				got.sex    = m_tdata[alfl_pkg::SLOT_W + alfl_pkg::ID_W +: alfl_pkg::SEX_W];
				got.name   = m_tdata[alfl_pkg::SLOT_W + alfl_pkg::ID_W + alfl_pkg::SEX_W +:
					alfl_pkg::NAME_W];
				got.prog   = m_tdata[alfl_pkg::SLOT_W + alfl_pkg::ID_W + alfl_pkg::SEX_W +
					alfl_pkg::NAME_W +: alfl_pkg::PROG_W];
				if (open_results.size() == 0) begin
					$error("result with no request pending: status %0d slot %0d",
						got.status, got.slot);
					fail_cnt++;
				end else begin
					want = open_results.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						fail_cnt++;
					end
					if (got.slot !== want.slot) begin
						$error("slot: expected %0d, actual %0d", want.slot, got.slot);
						fail_cnt++;
					end
					if (got.id !== want.id) begin
						$error("removed_id: expected %0h, actual %0h", want.id, got.id);
						fail_cnt++;
					end
					if (got.sex !== want.sex) begin
						$error("removed_sex: expected %0h, actual %0h", want.sex, got.sex);
						fail_cnt++;
					end
					if (got.name !== want.name) begin
						$error("removed_name: expected %0h, actual %0h", want.name, got.name);
						fail_cnt++;
					end
					if (got.prog !== want.prog) begin
						$error("removed_program: expected %0h, actual %0h",
							want.prog, got.prog);
						fail_cnt++;
					end
				end
				results_seen++;
			end
			// one long hold-off so the block backs up and stalls its input
			if (!long_hold_done && results_seen >= 300) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					hold_left = pick_gap((results_seen / 80) % 4 == 1);
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_array_linked_list_with_free_list failed");
			$finish;
		end
	end

	initial begin
		logic [alfl_pkg::NAME_W-1:0] name_a;
		logic [alfl_pkg::NAME_W-1:0] name_b;
		logic [alfl_pkg::NAME_W-1:0] names [6];
		logic [alfl_pkg::NAME_W-1:0] key;
		int                          insert_pct;
		int                          r;

		reset_pool();
		name_a = rand64();
		name_b = ~name_a;

		// Directed: empty list, field extremes, fill, full pool, removes at head,
		// middle and tail, duplicate names, key of zero and a miss on a full walk
		queue_req(alfl_pkg::MODE_REMOVE, $urandom(), $urandom(), name_a, rand64());
		queue_req(alfl_pkg::MODE_INSERT, '0, '0, '0, '0);
		queue_req(alfl_pkg::MODE_INSERT, '1, '1, '1, '1);
		queue_req(alfl_pkg::MODE_INSERT, $urandom(), $urandom(), name_a, rand64());
		for (int i = 0; i < 12; i++)
			queue_req(alfl_pkg::MODE_INSERT, $urandom(), $urandom(), rand64(), rand64());
		queue_req(alfl_pkg::MODE_INSERT, $urandom(), $urandom(), name_a, rand64());
		queue_req(alfl_pkg::MODE_INSERT, $urandom(), $urandom(), name_b, rand64());
		queue_req(alfl_pkg::MODE_REMOVE, $urandom(), $urandom(), '1, rand64());
		queue_req(alfl_pkg::MODE_REMOVE, $urandom(), $urandom(), name_a, rand64());
		queue_req(alfl_pkg::MODE_REMOVE, $urandom(), $urandom(), '0, rand64());
		queue_req(alfl_pkg::MODE_REMOVE, $urandom(), $urandom(), name_b, rand64());
		queue_req(alfl_pkg::MODE_INSERT, $urandom(), $urandom(), name_b, rand64());
		queue_req(alfl_pkg::MODE_REMOVE, $urandom(), $urandom(), name_a, rand64());
		queue_req(alfl_pkg::MODE_REMOVE, $urandom(), $urandom(), name_b, rand64());

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Hold the sender until every directed result is back
		while (pending_reqs.size() > 0 || offer_next || s_tvalid || open_results.size() > 0)
			@(posedge clk);

		// Random: alternate fill-heavy and drain-heavy phases over a small set of
		// names so that matches, duplicates and a full pool come up often
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i % (4 * PHASE_LEN) == 0) begin
				for (int k = 0; k < 6; k++)
					names[k] = rand64();
			end
			insert_pct = ((i / PHASE_LEN) % 2 == 0) ? 80 : 25;
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 88)
				key = names[$urandom_range(0, 5)];
			else if (r < 50)
				key = rand64();
			else
				key = (r < 75) ? '0 : '1;
			if ($urandom_range(0, 99) < insert_pct)
				queue_req(alfl_pkg::MODE_INSERT, $urandom(), $urandom(), key, rand64());
			else
				queue_req(alfl_pkg::MODE_REMOVE, $urandom(), $urandom(), key, rand64());
		end

		// Drain, then allow for a result still in flight
		while (pending_reqs.size() > 0 || offer_next || s_tvalid || open_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fail_cnt == 0 && open_results.size() == 0)
			$display("tb_array_linked_list_with_free_list passed");
		else
			$display("tb_array_linked_list_with_free_list failed");
		$finish;
	end

endmodule

FILE: array_linked_list_with_free_list.f
src/alfl_pkg.sv
src/alfl_ram.sv
src/alfl_ctrl.sv
src/alfl_dp.sv
src/array_linked_list_with_free_list.sv
tb/sv/tb_array_linked_list_with_free_list.sv
